FILE: rtl/core/memory_hard_reference_index_map_assert.svh
// assertion macros for the reference index map
// expects clk_i and rst_ni in the scope of every use
`ifndef MEMORY_HARD_REFERENCE_INDEX_MAP_ASSERT_SVH
`define MEMORY_HARD_REFERENCE_INDEX_MAP_ASSERT_SVH
`ifndef SYNTH
`define HRIM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("hrim assertion failed");
`define HRIM_ASSERT_NEVER(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("hrim forbidden condition seen");
`else
`define HRIM_ASSERT(lbl, prop)
`define HRIM_ASSERT_NEVER(lbl, prop)
`endif
`endif

FILE: rtl/core/hrim_pkg.sv
// package for the reference index map: constants, stage payload types
// no dependencies

package hrim_pkg;

  localparam int unsigned SLICES = 4;
  localparam int unsigned NDIV   = 32;  // cells of the remainder chain
  localparam int unsigned NQ     = 8;   // cells of the shift quotient chain

  // configuration register indexes
  localparam logic REG_LANE_COUNT     = 1'b0;
  localparam logic REG_SEGMENT_BLOCKS = 1'b1;

  typedef struct packed {
    logic        very_first;
    logic        first_blk;
    logic        first;
    logic [1:0]  slice;
    logic [23:0] blk;
    logic [31:0] word;
    logic [31:0] sl;
    logic [31:0] ls;
  } s1_t;

  typedef struct packed {
    logic        very_first;
    logic        first_blk;
    logic [23:0] blk;
    logic [31:0] word;
    logic [31:0] sl;
    logic [31:0] ls;
    logic [31:0] b1;
    logic [31:0] b2;
    logic [31:0] p;
  } s2_t;

  // payload carried along both cell chains
  typedef struct packed {
    logic        very_first;
    logic        first_blk;
    logic        ge;
    logic        big;
    logic [31:0] word;
    logic [31:0] div;
    logic [31:0] q;
    logic [31:0] b1;
    logic [31:0] b2;
    logic [31:0] sl;
    logic [31:0] adj;
    logic [7:0]  quot;
  } pl_t;

endpackage

FILE: rtl/core/hrim_cell.sv
// one restoring division cell: shifts in a bit, subtracts the divisor if it fits
// depends on nothing

module hrim_cell (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] rem_i,
  input  logic        bit_i,
  input  logic [31:0] div_i,
  output logic [31:0] rem_o,
  output logic        qbit_o
);

  logic [32:0] trial;
  logic [32:0] diff;
  logic        fits;
  logic [31:0] rem_d, rem_q;
  logic        qbit_q;

  // trial subtract
  always_comb begin
    trial = {rem_i, bit_i};
    diff  = trial - {1'b0, div_i};
    fits  = (trial >= {1'b0, div_i});
    rem_d = fits ? diff[31:0] : trial[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      qbit_q <= fits;
    end
  end

  assign rem_o  = rem_q;
  assign qbit_o = qbit_q;

endmodule

FILE: rtl/core/memory_hard_reference_index_map.sv
// top level of the reference index map: set-up stages, two cell chains, output skid
// depends on hrim_pkg, hrim_cell and memory_hard_reference_index_map_assert.svh
// throughput: one beat per cycle, set by the 32-cell remainder chain and 8-cell shift chain
// the whole pipeline halts only while the one-entry skid register is full
// reset clears all valid flags and sets lane_count to 1 and segment_blocks to 2

`include "memory_hard_reference_index_map_assert.svh"

module memory_hard_reference_index_map (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        first_pass_i,
  input  logic [7:0]  lane_i,
  input  logic [1:0]  slice_i,
  input  logic [23:0] block_in_segment_i,
  input  logic [31:0] random_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] ref_idx_o,
  output logic        mapped_o
);

  localparam int unsigned NDIV = hrim_pkg::NDIV;
  localparam int unsigned NQ   = hrim_pkg::NQ;

  logic [7:0]  lanes_q;
  logic [23:0] seg_q;
  logic        en;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lanes_q <= 8'd1;
      seg_q   <= 24'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hrim_pkg::REG_LANE_COUNT:     lanes_q <= cfg_data_i[7:0];
        hrim_pkg::REG_SEGMENT_BLOCKS: seg_q   <= cfg_data_i;
        default:                      lanes_q <= lanes_q;
      endcase
    end
  end

  // stage 1: capture beat, segment-lane products
  hrim_pkg::s1_t s1_d, s1_q;
  logic          s1_v_q;

  always_comb begin
    s1_d.very_first = first_pass_i && (slice_i == 2'd0) && (block_in_segment_i < 24'd2);
    s1_d.first_blk  = (block_in_segment_i == 24'd0);
    s1_d.first      = first_pass_i;
    s1_d.slice      = slice_i;
    s1_d.blk        = block_in_segment_i;
    s1_d.word       = random_word_i;
    s1_d.sl         = 32'(seg_q * lanes_q);
    s1_d.ls         = 32'(seg_q * lane_i);
  end

  // stage 2: barriers and shift threshold
  hrim_pkg::s2_t s2_d, s2_q;
  logic          s2_v_q;
  logic [31:0]   tail_k, p_k;

  always_comb begin
    tail_k = 32'(hrim_pkg::SLICES) - 32'(s1_q.slice) - 32'd1;
    p_k    = (s1_q.slice != 2'd0) ? 32'(s1_q.slice) - 32'd1 : 32'(hrim_pkg::SLICES - 2);
    s2_d.very_first = s1_q.very_first;
    s2_d.first_blk  = s1_q.first_blk;
    s2_d.blk        = s1_q.blk;
    s2_d.word       = s1_q.word;
    s2_d.sl         = s1_q.sl;
    s2_d.ls         = s1_q.ls;
    s2_d.b1         = 32'(32'(s1_q.slice) * s1_q.sl);
    s2_d.b2         = s1_q.first ? s2_d.b1 : s2_d.b1 + 32'(tail_k * s1_q.sl);
    s2_d.p          = 32'(p_k * s1_q.sl);
  end

  // stage 3: modulus and final placement offset
  hrim_pkg::pl_t s3_d, s3_q;
  logic          s3_v_q;

  always_comb begin
    s3_d            = '0;
    s3_d.very_first = s2_q.very_first;
    s3_d.first_blk  = s2_q.first_blk;
    s3_d.word       = s2_q.word;
    s3_d.div        = s2_q.first_blk ? s2_q.b2 - 32'(lanes_q)
                                     : s2_q.b2 + 32'(s2_q.blk) - 32'd1;
    s3_d.q          = s2_q.p;
    s3_d.b1         = s2_q.b1;
    s3_d.b2         = s2_q.b2;
    s3_d.sl         = s2_q.sl;
    s3_d.adj        = s2_q.ls - (s2_q.b2 - s2_q.b1);
  end

  // remainder chain, one word bit per cell
  hrim_pkg::pl_t c1_pl_q [NDIV];
  logic [NDIV-1:0] c1_v_q;
  logic [31:0]     c1_rem [NDIV];

  for (genvar k = 0; k < NDIV; k++) begin : g_c1
    hrim_pkg::pl_t prev;
    logic [31:0]   prev_rem;
    if (k == 0) begin : g_head
      assign prev     = s3_q;
      assign prev_rem = '0;
    end else begin : g_body
      assign prev     = c1_pl_q[k-1];
      assign prev_rem = c1_rem[k-1];
    end

    hrim_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (prev_rem),
      .bit_i  (prev.word[NDIV-1-k]),
      .div_i  (prev.div),
      .rem_o  (c1_rem[k]),
      .qbit_o ()
    );

    always_ff @(posedge clk_i) begin
      if (en) begin
        c1_pl_q[k] <= prev;
      end
    end
  end

  // stage 4: threshold test and quotient range check
  hrim_pkg::pl_t s4_d, s4_q;
  logic          s4_v_q;
  logic [31:0]   rq, xd, dd;

  always_comb begin
    rq        = c1_rem[NDIV-1];
    xd        = rq - c1_pl_q[NDIV-1].q;
    dd        = 32'(seg_q) - 32'd1;
    s4_d      = c1_pl_q[NDIV-1];
    s4_d.ge   = (rq >= c1_pl_q[NDIV-1].q);
    s4_d.big  = ({8'd0, xd} >= {dd, 8'd0});
    s4_d.q    = rq;
    s4_d.word = xd;
    s4_d.div  = dd;
    s4_d.quot = '0;
  end

  // shift quotient chain, low eight bits only
  hrim_pkg::pl_t c2_pl_q [NQ];
  logic [NQ-1:0] c2_v_q;
  logic [31:0]   c2_rem [NQ];
  logic [NQ-1:0] c2_qbit;

  for (genvar k = 0; k < NQ; k++) begin : g_c2
    hrim_pkg::pl_t prev;
    hrim_pkg::pl_t nxt;
    logic [31:0]   prev_rem;
    if (k == 0) begin : g_head
      assign prev     = s4_q;
      assign prev_rem = {8'd0, s4_q.word[31:8]};
      assign nxt      = s4_q;
    end else begin : g_body
      assign prev     = c2_pl_q[k-1];
      assign prev_rem = c2_rem[k-1];
      always_comb begin
        nxt      = c2_pl_q[k-1];
        nxt.quot = {c2_pl_q[k-1].quot[6:0], c2_qbit[k-1]};
      end
    end

    hrim_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (prev_rem),
      .bit_i  (prev.word[NQ-1-k]),
      .div_i  (prev.div),
      .rem_o  (c2_rem[k]),
      .qbit_o (c2_qbit[k])
    );

    always_ff @(posedge clk_i) begin
      if (en) begin
        c2_pl_q[k] <= nxt;
      end
    end
  end

  // stage 5: capped shift of the first block of a segment
  hrim_pkg::pl_t s5_d, s5_q;
  logic          s5_v_q;
  logic [31:0]   sh, shc;

  always_comb begin
    sh   = c2_pl_q[NQ-1].big ? '1 : {24'd0, c2_pl_q[NQ-1].quot[6:0], c2_qbit[NQ-1]};
    shc  = (sh > 32'(lanes_q)) ? 32'(lanes_q) : sh;
    s5_d = c2_pl_q[NQ-1];
    if (c2_pl_q[NQ-1].first_blk && c2_pl_q[NQ-1].ge) begin
      s5_d.q = c2_pl_q[NQ-1].q + shc;
    end
  end

  // stage 6: place into whole-memory numbering
  logic [31:0] res_d, res_q;
  logic        res_map_d, res_map_q, res_v_q;

  always_comb begin
    if (s5_q.very_first) begin
      res_d = '0;
    end else if (s5_q.q < s5_q.b1) begin
      res_d = s5_q.q;
    end else if (s5_q.q < s5_q.b2) begin
      res_d = s5_q.q + s5_q.sl;
    end else begin
      res_d = s5_q.q + s5_q.adj;
    end
    res_map_d = !s5_q.very_first;
  end

  // stage payload registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q      <= s1_d;
      s2_q      <= s2_d;
      s3_q      <= s3_d;
      s4_q      <= s4_d;
      s5_q      <= s5_d;
      res_q     <= res_d;
      res_map_q <= res_map_d;
    end
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      c1_v_q  <= '0;
      s4_v_q  <= 1'b0;
      c2_v_q  <= '0;
      s5_v_q  <= 1'b0;
      res_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q  <= in_valid_i;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      c1_v_q  <= {c1_v_q[NDIV-2:0], s3_v_q};
      s4_v_q  <= c1_v_q[NDIV-1];
      c2_v_q  <= {c2_v_q[NQ-2:0], s4_v_q};
      s5_v_q  <= c2_v_q[NQ-1];
      res_v_q <= s5_v_q;
    end
  end

  // output register with one-beat skid
  logic        out_v_d, out_v_q, skid_v_d, skid_v_q, out_load;
  logic [31:0] out_ref_d, out_ref_q, skid_ref_d, skid_ref_q;
  logic        out_map_d, out_map_q, skid_map_d, skid_map_q;

  assign en = !skid_v_q;

  always_comb begin
    out_load   = !out_v_q || !out_stall_i;
    out_v_d    = out_v_q;
    out_ref_d  = out_ref_q;
    out_map_d  = out_map_q;
    skid_v_d   = skid_v_q;
    skid_ref_d = skid_ref_q;
    skid_map_d = skid_map_q;
    if (out_load) begin
      skid_v_d = 1'b0;
      if (skid_v_q) begin
        out_v_d   = 1'b1;
        out_ref_d = skid_ref_q;
        out_map_d = skid_map_q;
      end else begin
        out_v_d   = res_v_q;
        out_ref_d = res_q;
        out_map_d = res_map_q;
      end
    end else if (en && res_v_q) begin
      skid_v_d   = 1'b1;
      skid_ref_d = res_q;
      skid_map_d = res_map_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_ref_q  <= out_ref_d;
    out_map_q  <= out_map_d;
    skid_ref_q <= skid_ref_d;
    skid_map_q <= skid_map_d;
  end

  assign in_stall_o  = skid_v_q;
  assign out_valid_o = out_v_q;
  assign ref_idx_o   = out_ref_q;
  assign mapped_o    = out_map_q;

  // checks
  `HRIM_ASSERT(a_skid_fill, $rose(skid_v_q) |-> $past(out_v_q && out_stall_i))
  `HRIM_ASSERT(a_skid_behind_out, skid_v_q |-> out_v_q)
  `HRIM_ASSERT(a_unmapped_zero, (out_v_q && !out_map_q) |-> (out_ref_q == 32'd0))
  `HRIM_ASSERT_NEVER(a_rem_bound, c1_v_q[NDIV-1] && (c1_pl_q[NDIV-1].div != 32'd0)
    && (c1_rem[NDIV-1] >= c1_pl_q[NDIV-1].div))

endmodule
